@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file i2ccd_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, for a property that must hold whenever an enable is high
`define ASSERT_CLK_EN(lbl, clk, rst_n, en, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (prop)) else $error(msg);

`endif

@@ rtl/i2ccd_pkg.sv @@
// types and constants for the i2c clock divider search
// no dependencies
package i2ccd_pkg;

  localparam int RateW  = 23;  // requested bit rate
  localparam int ClkW   = 32;  // source clock in hz
  localparam int ProdW  = 28;  // rate * count * 2, at most 18 * (2^23 - 1)
  localparam int QuotW  = 16;  // divider bits below the clamp
  localparam int CodeW  = 16;
  localparam int SclW   = 3;
  localparam int CntW   = 4;

  localparam logic [ClkW-1:0] ClkHzReset = 32'd12000000;
  localparam logic [CntW-1:0] SclFirst   = 4'd9;
  localparam logic [CntW-1:0] SclLast    = 4'd2;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_START,
    CTL_WAIT,
    CTL_OUT
  } ctl_state_e;

  typedef struct packed {
    logic             start;
    logic [ClkW-1:0]  num;
    logic [ProdW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             clamp;  // quotient reached the 65536 limit
    logic [QuotW-1:0] quot;
    logic [ClkW-1:0]  err;    // num - den * divider, modulo 2^32
  } div_res_t;

endpackage

@@ rtl/i2ccd_div.sv @@
// bit-serial restoring divider with clamp at 2^16
// depends on i2ccd_pkg
module i2ccd_div
  import i2ccd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  localparam int StepW = $clog2(QuotW);
  localparam logic [StepW-1:0] StepLast = StepW'(QuotW - 1);

  div_state_e state_q, state_d;

  logic [StepW-1:0] step_q;
  logic [ProdW-1:0] den_q;
  logic [ProdW-1:0] rem_q;
  logic [QuotW-1:0] low_q;  // remaining numerator bits, then quotient bits
  logic             clamp_q;
  logic [ClkW-1:0]  err_q;

  logic             clamp_now;
  logic [ProdW:0]   trial;
  logic [ProdW:0]   diff;
  logic             ge;
  logic [ClkW-1:0]  clamp_err;

  // upper half of the clock at or above den means the quotient is 2^16 or more
  assign clamp_now = {{(ProdW-QuotW){1'b0}}, req_i.num[ClkW-1:QuotW]} >= req_i.den;
  assign clamp_err = req_i.num - {req_i.den[QuotW-1:0], {QuotW{1'b0}}};

  assign trial = {rem_q, low_q[QuotW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          state_d = clamp_now ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (step_q == StepLast) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    res_o.done  = (state_q == DIV_DONE);
    res_o.clamp = clamp_q;
    res_o.quot  = low_q;
    res_o.err   = clamp_q ? err_q : {{(ClkW-ProdW){1'b0}}, rem_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
      clamp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_IDLE && req_i.start) begin
        step_q  <= '0;
        clamp_q <= clamp_now;
      end else if (state_q == DIV_RUN) begin
        step_q <= step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && req_i.start) begin
      den_q <= req_i.den;
      // not clamped: upper clock half is below den and fits the remainder
      rem_q <= {{(ProdW-QuotW){1'b0}}, req_i.num[ClkW-1:QuotW]};
      low_q <= req_i.num[QuotW-1:0];
      err_q <= clamp_err;
    end else if (state_q == DIV_RUN) begin
      rem_q <= ge ? diff[ProdW-1:0] : trial[ProdW-1:0];
      low_q <= {low_q[QuotW-2:0], ge};
    end
  end

endmodule

@@ rtl/i2ccd_ctrl.sv @@
// search sequencer: walks scl counts 9 down to 2, keeps the best candidate
// depends on i2ccd_pkg, drives i2ccd_div through div_req_t / div_res_t
module i2ccd_ctrl
  import i2ccd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ClkW-1:0]  clk_hz_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RateW-1:0] in_rate_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CodeW-1:0] out_code_o,
  output logic [SclW-1:0]  out_scl_o,
  output div_req_t         div_req_o,
  input  div_res_t         div_res_i
);

  ctl_state_e state_q, state_d;

  logic [RateW:0]   rate2_q;  // rate * 2, step between counts
  logic [ProdW-1:0] prod_q;
  logic [CntW-1:0]  cnt_q;
  logic [CodeW-1:0] best_code_q;
  logic [CntW-1:0]  best_cnt_q;
  logic [ClkW-1:0]  least_err_q;
  logic             out_valid_q;
  logic [CodeW-1:0] out_code_q;
  logic [SclW-1:0]  out_scl_q;

  logic             accept;
  logic             out_load;
  logic             upd;
  logic             stop;
  logic [CodeW-1:0] cand_code;
  logic [ProdW-1:0] prod_first;
  logic [CntW-1:0]  scl_diff;

  // rate * 18 as two shifted terms
  assign prod_first = {{(ProdW-RateW-4){1'b0}}, in_rate_i, 4'b0}
                    + {{(ProdW-RateW-1){1'b0}}, in_rate_i, 1'b0};

  assign cand_code = div_res_i.clamp ? '1 : div_res_i.quot - CodeW'(1);
  // zero best error means nothing chosen yet
  assign upd  = (div_res_i.err < least_err_q) || (least_err_q == '0);
  assign stop = (div_res_i.err == '0) || div_res_i.clamp || (cnt_q == SclLast);
  assign scl_diff = best_cnt_q - SclLast;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (in_valid_i) begin
          state_d = CTL_START;
        end
      end
      CTL_START: state_d = CTL_WAIT;
      CTL_WAIT: begin
        if (div_res_i.done) begin
          state_d = stop ? CTL_OUT : CTL_START;
        end
      end
      CTL_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == CTL_IDLE);
    accept          = in_ready_o && in_valid_i;
    out_load        = (state_q == CTL_OUT) && (!out_valid_q || out_ready_i);
    div_req_o.start = (state_q == CTL_START);
    div_req_o.num   = clk_hz_i;
    div_req_o.den   = prod_q;
    out_valid_o     = out_valid_q;
    out_code_o      = out_code_q;
    out_scl_o       = out_scl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rate2_q     <= {in_rate_i, 1'b0};
      prod_q      <= prod_first;
      cnt_q       <= SclFirst;
      least_err_q <= '0;
    end else if (state_q == CTL_WAIT && div_res_i.done) begin
      if (upd) begin
        best_code_q <= cand_code;
        best_cnt_q  <= cnt_q;
        least_err_q <= div_res_i.err;
      end
      cnt_q  <= cnt_q - CntW'(1);
      prod_q <= prod_q - {{(ProdW-RateW-1){1'b0}}, rate2_q};
    end
    if (out_load) begin
      out_code_q <= best_code_q;
      out_scl_q  <= scl_diff[SclW-1:0];
    end
  end

endmodule

@@ rtl/i2c_clock_divider_search_top.sv @@
// channel   dir  tdata bits (low first)                      item
// s_axis    in   [22:0] bit_rate, [23] zero                  one rate request
// m_axis    out  [15:0] divider_code, [18:16] scl_time_code  one result
// cfg       in   cfg_wdata_i = source_clock_hz               register write
//
// one item at a time: each scl count tried runs the bit-serial divider,
// which skips its bit steps when it clamps; up to 8 counts are tried
// between the accept and the hand-off of an item
// reset clears the sequencer and output valid; source clock resets to 12 MHz
// a held result does not stop the search of the next item, only its hand-off
//
// top level: config register, stream packing, sequencer and divider
// depends on i2ccd_pkg, i2ccd_div, i2ccd_ctrl
module i2c_clock_divider_search_top
  import i2ccd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,    // source_clock_hz
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [22:0] bit_rate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] divider_code, [18:16] scl_time_code
);

  logic [ClkW-1:0]  clk_hz_q;
  logic [CodeW-1:0] code;
  logic [SclW-1:0]  scl;
  div_req_t         div_req;
  div_res_t         div_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkHzReset;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_wdata_i;
    end
  end

  i2ccd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clk_hz_i    (clk_hz_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_rate_i   (s_axis_tdata[RateW-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (code),
    .out_scl_o   (scl),
    .div_req_o   (div_req),
    .div_res_i   (div_res)
  );

  i2ccd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign m_axis_tdata = {{(24-CodeW-SclW){1'b0}}, scl, code};

endmodule

@@ rtl/i2ccd_checker.sv @@
// port-level checks for i2c_clock_divider_search_top, bound to it below
// depends on assert_macros.svh
`include "assert_macros.svh"

module i2ccd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a result stays offered until taken
  `ASSERT_CLK(a_m_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped before taken")
  `ASSERT_CLK(a_m_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result changed")
  // one item in the search at a time
  `ASSERT_CLK(a_one_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while searching")
  // a new result only comes out of a running search
  `ASSERT_CLK(a_from_search, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without a search")
  `ASSERT_CLK_EN(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[23:19] == 5'd0, "pad bits set")

endmodule

bind i2c_clock_divider_search_top i2ccd_checker u_i2ccd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/i2c_clock_divider_search_top_test.sv @@
// testbench for i2c_clock_divider_search_top: predicts divider and scl codes per rate item
// and checks every result on the master stream in order
// depends on i2ccd_pkg and the rtl of i2c_clock_divider_search_top
`timescale 1ns / 100ps

module i2c_clock_divider_search_top_test
  import i2ccd_pkg::*;
();

  localparam logic [31:0] DivClamp     = 32'h10000;
  localparam int          CycleLimit   = 2_000_000;
  localparam int          SettleCycles = 200;
  localparam int          ItemsPerClk  = 100;

  typedef struct packed {
    logic [CodeW-1:0] divider_code;
    logic [SclW-1:0]  scl_time_code;
  } scl_setting_t;

  // keeps its own copy of the source clock and the settings still owed by the block
  class divider_scoreboard;
    logic [ClkW-1:0] source_clock_hz;
    scl_setting_t    expected_settings[$];
    int              errors;

    function new();
      source_clock_hz = ClkHzReset;
      errors = 0;
    endfunction

    // walk the scl counts from the first down, keeping the smallest error; a zero error or a clamp ends the walk
    function scl_setting_t search_divider(logic [RateW-1:0] rate);
      logic [31:0]     prod;
      logic [31:0]     quot;
      logic [31:0]     err;
      logic [31:0]     pick_div;
      logic [31:0]     pick_err;
      logic [CntW-1:0] cnt;
      logic [CntW-1:0] best_cnt;
      logic [CntW-1:0] scl_offset;
      bit              done;
      scl_setting_t    setting;
      pick_div = '0;
      pick_err = '0;
      best_cnt = SclFirst;
      done = 1'b0;
      for (cnt = SclFirst; cnt >= SclLast && !done; cnt--) begin
        prod = 32'(rate) * 32'(cnt) * 32'd2;
        // a zero period product divides to all ones
        quot = (prod == '0) ? '1 : source_clock_hz / prod;
        if (quot > DivClamp) quot = DivClamp;
        err = source_clock_hz - prod * quot;
        if (err < pick_err || pick_err == '0) begin
          pick_div = quot;
          pick_err = err;
          best_cnt = cnt;
        end
        if (err == '0 || quot >= DivClamp) done = 1'b1;
      end
      setting.divider_code = CodeW'(pick_div - 32'd1);
      scl_offset = best_cnt - SclLast;
      setting.scl_time_code = scl_offset[SclW-1:0];
      return setting;
    endfunction

    function void note_rate(logic [RateW-1:0] rate);
      expected_settings.push_back(search_divider(rate));
    endfunction

    function void check_result(logic [23:0] tdata);
      scl_setting_t want;
      logic [CodeW-1:0] got_div;
      logic [SclW-1:0]  got_scl;
      got_div = tdata[15:0];
      got_scl = tdata[18:16];
      if (expected_settings.size() == 0) begin
        $error("result with nothing pending: divider_code %0d scl_time_code %0d",
               got_div, got_scl);
        errors++;
        return;
      end
      want = expected_settings.pop_front();
      if (got_div !== want.divider_code) begin
        $error("divider_code: expected %0d, got %0d", want.divider_code, got_div);
        errors++;
      end
      if (got_scl !== want.scl_time_code) begin
        $error("scl_time_code: expected %0d, got %0d", want.scl_time_code, got_scl);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [22:0] bit_rate
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] divider_code, [18:16] scl_time_code

  divider_scoreboard sb = new();

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;

  i2c_clock_divider_search_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("i2c_clock_divider_search_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // entered right after a falling edge, returns right after one; valid stays high
  task automatic send_rate(input logic [RateW-1:0] rate);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, rate};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_rate(rate);
    @(negedge clk_i);
  endtask

  // stop offering items and wait until every result is back and the block is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_settings.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_source_clock(input logic [31:0] hz);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.source_clock_hz = hz;
  endtask

  function automatic logic [31:0] pick_clock();
    case ($urandom_range(5))
      0: return 32'd12000000;
      1: return 32'd48000000;
      2: return 32'hFFFFFFFF;
      3: return $urandom();
      4: return $urandom_range(1000, 1);
      default: return $urandom_range(100000000, 1000000);
    endcase
  endfunction

  function automatic logic [RateW-1:0] pick_rate();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 23'd100000;
          1: return 23'd400000;
          2: return 23'd1000000;
          default: return 23'd3400000;
        endcase
      end
      1: return RateW'($urandom_range(2000000, 1));
      2: return (raw[RateW-1:0] == '0) ? 23'd1 : raw[RateW-1:0];
      default: return RateW'($urandom_range(1000, 1));
    endcase
  endfunction

  task automatic send_directed();
    // default 12 MHz clock: zero rate, extremes, bus standard rates, alternating bits
    send_rate(23'd0);
    send_rate(23'd1);
    send_rate(23'h7FFFFF);
    send_rate(23'd100000);
    send_rate(23'd400000);
    send_rate(23'd1000000);
    send_rate(23'd3400000);
    send_rate(23'h555555);
    send_rate(23'h2AAAAA);
    // zero clock gives zero error at once: a zero divider, or a clamped one for a zero rate
    drain();
    write_source_clock(32'd0);
    send_rate(23'd0);
    send_rate(23'd1);
    send_rate(23'h7FFFFF);
    // period product above the clock: divider zero wraps the code
    drain();
    write_source_clock(32'd1);
    send_rate(23'd1);
    send_rate(23'h7FFFFF);
    // largest clock: small rates clamp the divider, the largest rate does not
    drain();
    write_source_clock(32'hFFFFFFFF);
    send_rate(23'd0);
    send_rate(23'd1);
    send_rate(23'd2);
    send_rate(23'h7FFFFF);
    drain();
    write_source_clock(32'd48000000);
    send_rate(23'd100000);
    send_rate(23'd400000);
    send_rate(23'd1000000);
  endtask

  initial begin
    int phase;
    int blk;
    int i;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(negedge clk_i);

    send_directed();

    for (phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 75; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 75; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      for (blk = 0; blk < 4; blk++) begin
        drain();
        write_source_clock(pick_clock());
        // long receiver hold-off so the block fills and backs up its input
        if (phase == 0 && blk == 1) hold_request = 1500;
        for (i = 0; i < ItemsPerClk; i++) send_rate(pick_rate());
      end
    end

    drain();
    if (sb.expected_settings.size() != 0) begin
      $error("%0d results never arrived", sb.expected_settings.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("i2c_clock_divider_search_top_test OK");
    end else begin
      $display("i2c_clock_divider_search_top_test NOT OK");
    end
    $finish;
  end

endmodule
